// ===== rtl/core/mttu_pkg.sv =====
// Package for the mean threshold pixel to tone unit.
// Field widths, register indexes, defaults and the controller/datapath structs.
// No dependencies.
package mttu_pkg;

  localparam int PIX_W     = 8;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 2;
  localparam int TONE_W    = 15;
  localparam int THR_W     = 8;
  localparam int STEP_W    = 13;
  localparam int OUT_W     = TONE_W + 1 + THR_W;
  localparam int DIV_Q_W   = STEP_W;

  localparam int MTTU_MAX_ROWS   = 4096;
  localparam int MTTU_MAX_PIXELS = 16777216;

  localparam logic [TONE_W-1:0] TONE_MAX = '1;
  localparam logic [THR_W-1:0]  THR_MAX  = '1;

  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPAN   = 2'd2;

  localparam logic [CFG_W-1:0] HEIGHT_RST = 13'd256;
  localparam logic [CFG_W-1:0] BASE_RST   = 13'd2000;
  localparam logic [CFG_W-1:0] SPAN_RST   = 13'd3000;

  typedef struct packed {
    logic acc;        // accumulate the live pixel
    logic cls_live;   // classify the live pixel into the output register
    logic cls_held;   // classify the captured pixel into the output register
    logic capture;    // hold the live pixel for a pass switch
    logic div_go;     // start the divider
    logic div_step;   // 0: threshold operands, 1: row step operands
    logic load_thr;
    logic load_step;
    logic enter_cls;  // enter the classify pass, row back to zero
  } mttu_cmd_t;

  typedef struct packed {
    logic div_done;
    logic in_cls;
  } mttu_sts_t;

endpackage

// ===== rtl/core/mttu_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Used for the rounded-up mean and the row step. Depends on nothing.
module mttu_div #(
  parameter int NUM_W = 34,
  parameter int DEN_W = 25,
  parameter int QUO_W = 13
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [QUO_W-1:0] quot
);

  localparam int SH_W  = DEN_W + QUO_W - 1;
  localparam int CMP_W = (NUM_W > SH_W) ? NUM_W : SH_W;
  localparam int CNT_W = (QUO_W > 1) ? $clog2(QUO_W) : 1;

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [NUM_W-1:0] rem_r, rem_nxt;
  logic [SH_W-1:0]  dsh_r, dsh_nxt;
  logic [QUO_W-1:0] quot_r, quot_nxt;
  logic [CMP_W-1:0] diff;
  logic             fits;

  assign fits = CMP_W'(rem_r) >= CMP_W'(dsh_r);
  assign diff = CMP_W'(rem_r) - CMP_W'(dsh_r);

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dsh_nxt  = dsh_r;
    quot_nxt = quot_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(QUO_W - 1);
      rem_nxt  = num;
      dsh_nxt  = SH_W'(den) << (QUO_W - 1);
      quot_nxt = '0;
    end else if (busy_r) begin
      if (fits) begin
        rem_nxt = diff[NUM_W-1:0];
      end
      quot_nxt = {quot_r[QUO_W-2:0], fits};
      dsh_nxt  = dsh_r >> 1;
      cnt_nxt  = cnt_r - CNT_W'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r  <= rem_nxt;
    dsh_r  <= dsh_nxt;
    quot_r <= quot_nxt;
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

// ===== rtl/core/mttu_dp.sv =====
// Datapath: config registers, sum and count, row counter, threshold, step, tone.
// Depends on mttu_pkg and mttu_div.
module mttu_dp #(
  parameter int MAX_ROWS   = mttu_pkg::MTTU_MAX_ROWS,
  parameter int MAX_PIXELS = mttu_pkg::MTTU_MAX_PIXELS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [mttu_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mttu_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic [mttu_pkg::PIX_W-1:0]     in_pix,
  input  mttu_pkg::mttu_cmd_t            cmd,
  output mttu_pkg::mttu_sts_t            sts,
  output logic [mttu_pkg::OUT_W-1:0]     out_data
);
  import mttu_pkg::*;

  localparam int CNT_W   = $clog2(MAX_PIXELS + 1);
  localparam int SUM_W   = CNT_W + PIX_W;
  localparam int ROW_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int HGT_W   = (ROW_W + 1 > CFG_W) ? ROW_W + 1 : CFG_W;
  localparam int NUM_W   = ((SUM_W > HGT_W) ? SUM_W : HGT_W) + 1;
  localparam int DEN_W   = (CNT_W > HGT_W) ? CNT_W : HGT_W;
  localparam int PROD_W  = ROW_W + STEP_W;
  localparam int TONE_CW = PROD_W + 1;

  logic [CFG_W-1:0]  height_r, base_r, span_r;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [THR_W-1:0]  thr_r, thr_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              cls_r, cls_nxt;
  logic [PIX_W-1:0]  pix_r;
  logic [OUT_W-1:0]  out_r;

  logic [HGT_W-1:0]   h_eff;
  logic [SUM_W-1:0]   sum_base;
  logic [CNT_W-1:0]   cnt_base;
  logic [PIX_W-1:0]   pix_sel;
  logic               bright;
  logic [PROD_W-1:0]  prod;
  logic [TONE_CW-1:0] tone_sum;
  logic [TONE_W-1:0]  tone;
  logic [NUM_W-1:0]   div_num;
  logic [DEN_W-1:0]   div_den;
  logic               div_done;
  logic [DIV_Q_W-1:0] div_quot;

  always_comb begin
    if (height_r == '0) begin
      h_eff = HGT_W'(1);
    end else if (HGT_W'(height_r) > HGT_W'(MAX_ROWS)) begin
      h_eff = HGT_W'(MAX_ROWS);
    end else begin
      h_eff = HGT_W'(height_r);
    end
  end

  always_comb begin
    if (cmd.div_step) begin
      div_num = NUM_W'(span_r) + NUM_W'(h_eff) - NUM_W'(1);
      div_den = DEN_W'(h_eff);
    end else begin
      div_num = NUM_W'(sum_r) + NUM_W'(cnt_r) - NUM_W'(1);
      div_den = DEN_W'(cnt_r);
    end
  end

  mttu_div #(
    .NUM_W(NUM_W),
    .DEN_W(DEN_W),
    .QUO_W(DIV_Q_W)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(cmd.div_go),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quot (div_quot)
  );

  assign sum_base = cls_r ? '0 : sum_r;
  assign cnt_base = cls_r ? '0 : cnt_r;
  assign pix_sel  = cmd.cls_held ? pix_r : in_pix;
  assign bright   = pix_sel >= thr_r;
  assign prod     = PROD_W'(row_r) * PROD_W'(step_r);
  assign tone_sum = TONE_CW'(base_r) + TONE_CW'(prod);

  always_comb begin
    if (!bright) begin
      tone = '0;
    end else if (tone_sum > TONE_CW'(TONE_MAX)) begin
      tone = TONE_MAX;
    end else begin
      tone = tone_sum[TONE_W-1:0];
    end
  end

  always_comb begin
    sum_nxt  = sum_r;
    cnt_nxt  = cnt_r;
    row_nxt  = row_r;
    thr_nxt  = thr_r;
    step_nxt = step_r;
    cls_nxt  = cls_r;
    if (cmd.acc) begin
      cls_nxt = 1'b0;
      sum_nxt = sum_base;
      cnt_nxt = cnt_base;
      if (cls_r) begin
        row_nxt = '0;
      end
      if (cnt_base < CNT_W'(MAX_PIXELS)) begin
        sum_nxt = sum_base + SUM_W'(in_pix);
        cnt_nxt = cnt_base + CNT_W'(1);
      end
    end
    if (cmd.load_thr) begin
      if (cnt_r == '0) begin
        thr_nxt = '0;
      end else if (div_quot > DIV_Q_W'(THR_MAX)) begin
        thr_nxt = THR_MAX;
      end else begin
        thr_nxt = div_quot[THR_W-1:0];
      end
    end
    if (cmd.load_step) begin
      step_nxt = div_quot;
    end
    if (cmd.enter_cls) begin
      cls_nxt = 1'b1;
      row_nxt = '0;
    end
    if (cmd.cls_live || cmd.cls_held) begin
      if (HGT_W'(row_r) + HGT_W'(1) >= h_eff) begin
        row_nxt = '0;
      end else begin
        row_nxt = row_r + ROW_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      height_r <= HEIGHT_RST;
      base_r   <= BASE_RST;
      span_r   <= SPAN_RST;
      sum_r    <= '0;
      cnt_r    <= '0;
      row_r    <= '0;
      thr_r    <= '0;
      step_r   <= '0;
      cls_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_HEIGHT: height_r <= cfg_wdata;
          REG_BASE:   base_r   <= cfg_wdata;
          REG_SPAN:   span_r   <= cfg_wdata;
          default: ;
        endcase
      end
      sum_r  <= sum_nxt;
      cnt_r  <= cnt_nxt;
      row_r  <= row_nxt;
      thr_r  <= thr_nxt;
      step_r <= step_nxt;
      cls_r  <= cls_nxt;
    end
    if (cmd.capture) begin
      pix_r <= in_pix;
    end
    if (cmd.cls_live || cmd.cls_held) begin
      out_r <= {thr_r, bright, tone};
    end
  end

  assign sts.div_done = div_done;
  assign sts.in_cls   = cls_r;
  assign out_data     = out_r;

endmodule

// ===== rtl/core/mttu_ctrl.sv =====
// Controller: input/output handshake, pass switch sequencing, output valid.
// Depends on mttu_pkg.
module mttu_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  input  logic                in_req,
  output logic                in_tready,
  output logic                out_tvalid,
  input  logic                out_tready,
  input  mttu_pkg::mttu_sts_t sts,
  output mttu_pkg::mttu_cmd_t cmd
);
  import mttu_pkg::*;

  typedef enum logic [1:0] {
    S_RUN,
    S_THR,
    S_STEP,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_vld_r, out_vld_nxt;
  logic   in_xfer;

  assign in_tready = (state_r == S_RUN) && (!out_vld_r || out_tready);
  assign in_xfer   = in_tvalid && in_tready;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_RUN: begin
        if (in_xfer) begin
          if (!in_req) begin
            cmd.acc = 1'b1;
          end else if (sts.in_cls) begin
            cmd.cls_live = 1'b1;
          end else begin
            cmd.capture = 1'b1;
            cmd.div_go  = 1'b1;
            state_nxt   = S_THR;
          end
        end
      end
      S_THR: begin
        if (sts.div_done) begin
          cmd.load_thr = 1'b1;
          cmd.div_go   = 1'b1;
          cmd.div_step = 1'b1;
          state_nxt    = S_STEP;
        end
      end
      S_STEP: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) begin
          cmd.load_step = 1'b1;
          cmd.enter_cls = 1'b1;
          state_nxt     = S_EMIT;
        end
      end
      S_EMIT: begin
        cmd.cls_held = 1'b1;
        state_nxt    = S_RUN;
      end
      default: state_nxt = S_RUN;
    endcase
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (cmd.cls_live || cmd.cls_held) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_RUN;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  assign out_tvalid = out_vld_r;

endmodule

// ===== rtl/core/mean_threshold_pixel_to_tone_unit.sv =====
// Top level of the mean threshold pixel to tone unit.
// Depends on mttu_pkg, mttu_ctrl, mttu_dp (which holds mttu_div).
//
//  channel | direction | payload                                   | handshake
//  in_     | slave     | tdata: pixel_value; tuser: req_type        | tvalid/tready
//  out_    | master    | tdata: tone_freq, is_bright, threshold_used | tvalid/tready
//  cfg_    | write     | index 0 height, 1 base, 2 span             | wr_en
//
// Accumulate transfers and the later classify transfers of a pass do not use the divider.
// The first classify transfer of a pass first runs two 13-step divisions
// in the shared restoring divider, threshold then row step, then the tone.
// Reset is synchronous; config returns to defaults, no clearing pass.
// A held result blocks further input until it is taken.
module mean_threshold_pixel_to_tone_unit #(
  parameter int MAX_ROWS   = mttu_pkg::MTTU_MAX_ROWS,
  parameter int MAX_PIXELS = mttu_pkg::MTTU_MAX_PIXELS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [mttu_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mttu_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [mttu_pkg::PIX_W-1:0]     in_tdata,   // [7:0] pixel_value
  input  logic                           in_tuser,   // [0] req_type
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [mttu_pkg::OUT_W-1:0]     out_tdata   // [14:0] tone_freq, [15] is_bright,
                                                     // [23:16] threshold_used
);
  import mttu_pkg::*;

  mttu_cmd_t cmd;
  mttu_sts_t sts;

  mttu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_req    (in_tuser),
    .in_tready (in_tready),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mttu_dp #(
    .MAX_ROWS  (MAX_ROWS),
    .MAX_PIXELS(MAX_PIXELS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_pix   (in_tdata),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_tdata)
  );

endmodule

// ===== rtl/core/mttu_checker.sv =====
// Port level checks for the mean threshold pixel to tone unit, bound to the top.
// Depends on mttu_pkg.
module mttu_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_tvalid,
  input logic                       in_tready,
  input logic                       in_tuser,
  input logic                       out_tvalid,
  input logic                       out_tready,
  input logic [mttu_pkg::OUT_W-1:0] out_tdata
);
  import mttu_pkg::*;

  a_rst_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result dropped or changed");

  a_dark_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[TONE_W] |-> out_tdata[TONE_W-1:0] == '0)
    else $error("dark pixel carries a tone");

  a_acc_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tuser && !out_tvalid |=> !out_tvalid)
    else $error("accumulate transfer produced a result");

  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input taken while result is stalled");

endmodule

bind mean_threshold_pixel_to_tone_unit mttu_checker u_mttu_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .in_tuser  (in_tuser),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);
